// ----- hw/rtl/nwsm_pkg.sv -----
// Shared constants, codes and types for the score matrix hash core.
// Used by every module in hw/rtl except nwsm_ram; depends on nothing else.
package nwsm_pkg;

  localparam int unsigned MaxCols = 1024;
  localparam int unsigned AlphabetSize = 32;
  localparam int unsigned SymW = 5;
  localparam int unsigned PosW = 10;
  localparam int unsigned DimW = 11;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned SubstW = 8;
  localparam int unsigned SubstDepth = AlphabetSize * AlphabetSize;
  localparam int unsigned ColAddrW = $clog2(MaxCols);
  localparam int unsigned SubstAddrW = $clog2(SubstDepth);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DimW-1:0] DimLimit = DimW'(1024);
  localparam logic [ScoreW-1:0] HashSeed = ScoreW'(5381);
  localparam int unsigned HashShift = 5;

  typedef enum logic [1:0] {
    OP_CELL    = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAP  = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_COLS = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            first_row;
    logic            first_col;
    logic            last;
    logic            fwd;
  } cell_req_t;

  typedef struct packed {
    logic                 we;
    logic [ColAddrW-1:0]  addr;
    logic [ScoreW-1:0]    data;
  } row_wr_t;

endpackage

// ----- hw/rtl/nw_score_matrix_hash_core.sv -----
// Top level of the linear-gap score matrix core with a running cell hash.
// Depends on nwsm_pkg, nwsm_ram, nwsm_sched and nwsm_cell.
//
// Requests arrive on the in channel: opcode 0 computes the next cell in
// row-major order, opcode 1 loads a substitution entry, opcode 2 restarts
// the matrix. Only cell requests produce a result on the out channel,
// carrying the score, the running hash, the cell position and a flag on
// the final cell of the matrix. The cfg channel writes gap cost, row count
// and column count; it is always ready, but must be used only while the core
// is idle: the block itself does not enforce this. A cell request is accepted
// at edge t, and its row store and substitution reads are registered at that
// same edge. The cell is then computed from the read data and loaded into the
// output register as soon as that register is empty or being taken. One
// request is taken every cycle while the out channel keeps up. When the
// receiver stalls, the output register holds its result and one more cell
// waits in the compute stage; in_ready_o drops only while both are occupied.
// Reset clears the position to (0,0), the hash to its seed and the registers
// to their reset values; the memories are not cleared and need no clearing pass.
module nw_score_matrix_hash_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nwsm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [nwsm_pkg::DimW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      opcode_i,
  input  logic [nwsm_pkg::SymW-1:0]       x_symbol_i,
  input  logic [nwsm_pkg::SymW-1:0]       y_symbol_i,
  input  logic signed [7:0]               subst_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              score_o,
  output logic [31:0]                     hash_value_o,
  output logic [9:0]                      row_index_o,
  output logic [9:0]                      col_index_o,
  output logic                            last_cell_o
);

  logic [7:0]                           gap_cost_q;
  logic [nwsm_pkg::DimW-1:0]            row_count_q, col_count_q;
  logic [nwsm_pkg::DimW-1:0]            rows_eff, cols_eff;
  logic                                 accept;
  logic                                 req_valid;
  nwsm_pkg::cell_req_t                  req;
  nwsm_pkg::row_wr_t                    row_wr;
  logic                                 subst_we;
  logic [nwsm_pkg::SubstAddrW-1:0]      subst_addr;
  logic [nwsm_pkg::ColAddrW-1:0]        row_raddr;
  logic [nwsm_pkg::ScoreW-1:0]          up_rdata;
  logic [nwsm_pkg::SubstW-1:0]          subst_rdata;
  logic [nwsm_pkg::ScoreW-1:0]          score_raw;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_cost_q <= 8'hFF;
      row_count_q <= nwsm_pkg::DimW'(1);
      col_count_q <= nwsm_pkg::DimW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nwsm_pkg::CFG_GAP:  gap_cost_q <= cfg_data_i[7:0];
        nwsm_pkg::CFG_ROWS: row_count_q <= cfg_data_i;
        nwsm_pkg::CFG_COLS: col_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign rows_eff = (row_count_q == '0) ? nwsm_pkg::DimW'(1) :
                    (row_count_q > nwsm_pkg::DimLimit) ? nwsm_pkg::DimLimit : row_count_q;
  assign cols_eff = (col_count_q == '0) ? nwsm_pkg::DimW'(1) :
                    (col_count_q > nwsm_pkg::DimLimit) ? nwsm_pkg::DimLimit : col_count_q;

  assign accept = in_valid_i && in_ready_o;

  nwsm_sched u_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .opcode_i     (opcode_i),
    .x_symbol_i   (x_symbol_i),
    .y_symbol_i   (y_symbol_i),
    .rows_i       (rows_eff),
    .cols_i       (cols_eff),
    .row_wr_i     (row_wr),
    .req_valid_o  (req_valid),
    .req_o        (req),
    .subst_we_o   (subst_we),
    .subst_addr_o (subst_addr),
    .row_raddr_o  (row_raddr)
  );

  nwsm_ram #(
    .Width (nwsm_pkg::ScoreW),
    .Depth (nwsm_pkg::MaxCols)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (row_wr.we),
    .waddr_i (row_wr.addr),
    .wdata_i (row_wr.data),
    .re_i    (req_valid),
    .raddr_i (row_raddr),
    .rdata_o (up_rdata)
  );

  nwsm_ram #(
    .Width (nwsm_pkg::SubstW),
    .Depth (nwsm_pkg::SubstDepth)
  ) u_subst_table (
    .clk_i   (clk_i),
    .we_i    (subst_we),
    .waddr_i (subst_addr),
    .wdata_i (subst_value_i),
    .re_i    (req_valid),
    .raddr_i (subst_addr),
    .rdata_o (subst_rdata)
  );

  nwsm_cell u_cell (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_i         (req),
    .up_rdata_i    (up_rdata),
    .subst_rdata_i (subst_rdata),
    .gap_cost_i    (gap_cost_q),
    .ready_o       (in_ready_o),
    .row_wr_o      (row_wr),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .score_o       (score_raw),
    .hash_value_o  (hash_value_o),
    .row_index_o   (row_index_o),
    .col_index_o   (col_index_o),
    .last_cell_o   (last_cell_o)
  );

  assign score_o = $signed(score_raw);

endmodule

// ----- hw/rtl/nwsm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module nwsm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/nwsm_sched.sv -----
// Request stage: tracks the matrix position, issues memory reads for cells,
// writes substitution entries and flags row store forwarding. Uses nwsm_pkg.
module nwsm_sched (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [1:0]                          opcode_i,
  input  logic [nwsm_pkg::SymW-1:0]           x_symbol_i,
  input  logic [nwsm_pkg::SymW-1:0]           y_symbol_i,
  input  logic [nwsm_pkg::DimW-1:0]           rows_i,
  input  logic [nwsm_pkg::DimW-1:0]           cols_i,
  input  nwsm_pkg::row_wr_t                   row_wr_i,
  output logic                                req_valid_o,
  output nwsm_pkg::cell_req_t                 req_o,
  output logic                                subst_we_o,
  output logic [nwsm_pkg::SubstAddrW-1:0]     subst_addr_o,
  output logic [nwsm_pkg::ColAddrW-1:0]       row_raddr_o
);

  logic [nwsm_pkg::PosW-1:0] cur_row_q, cur_row_d;
  logic [nwsm_pkg::PosW-1:0] cur_col_q, cur_col_d;
  logic                      beyond;
  logic [nwsm_pkg::PosW-1:0] row_sel, col_sel;
  logic [nwsm_pkg::DimW-1:0] col_next;
  logic                      last;

  assign beyond = ({1'b0, cur_row_q} >= rows_i) || ({1'b0, cur_col_q} >= cols_i);
  assign row_sel = beyond ? '0 : cur_row_q;
  assign col_sel = beyond ? '0 : cur_col_q;
  assign col_next = {1'b0, col_sel} + nwsm_pkg::DimW'(1);
  assign last = ({1'b0, row_sel} == rows_i - nwsm_pkg::DimW'(1)) &&
                ({1'b0, col_sel} == cols_i - nwsm_pkg::DimW'(1));

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    if (accept_i) begin
      unique case (opcode_i)
        nwsm_pkg::OP_CELL: begin
          if (last) begin
            cur_row_d = '0;
            cur_col_d = '0;
          end else if (col_next >= cols_i) begin
            cur_row_d = row_sel + nwsm_pkg::PosW'(1);
            cur_col_d = '0;
          end else begin
            cur_row_d = row_sel;
            cur_col_d = col_next[nwsm_pkg::PosW-1:0];
          end
        end
        nwsm_pkg::OP_RESTART: begin
          cur_row_d = '0;
          cur_col_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
    end else begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
    end
  end

  assign req_valid_o = accept_i && (opcode_i == nwsm_pkg::OP_CELL);
  assign subst_we_o = accept_i && (opcode_i == nwsm_pkg::OP_LOAD);
  assign subst_addr_o = {y_symbol_i, x_symbol_i};
  assign row_raddr_o = col_sel;

  assign req_o.row = row_sel;
  assign req_o.col = col_sel;
  assign req_o.first_row = (row_sel == '0);
  assign req_o.first_col = (col_sel == '0);
  assign req_o.last = last;
  assign req_o.fwd = row_wr_i.we && (row_wr_i.addr == col_sel);

endmodule

// ----- hw/rtl/nwsm_cell.sv -----
// Cell stage: combines memory read data with the diagonal, left and hash
// registers, writes the row store and holds the output register. Uses nwsm_pkg.
module nwsm_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  input  nwsm_pkg::cell_req_t               req_i,
  input  logic [nwsm_pkg::ScoreW-1:0]       up_rdata_i,
  input  logic [nwsm_pkg::SubstW-1:0]       subst_rdata_i,
  input  logic [7:0]                        gap_cost_i,
  output logic                              ready_o,
  output nwsm_pkg::row_wr_t                 row_wr_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nwsm_pkg::ScoreW-1:0]       score_o,
  output logic [nwsm_pkg::ScoreW-1:0]       hash_value_o,
  output logic [nwsm_pkg::PosW-1:0]         row_index_o,
  output logic [nwsm_pkg::PosW-1:0]         col_index_o,
  output logic                              last_cell_o
);

  logic                          b_valid_q;
  nwsm_pkg::cell_req_t           b_req_q;
  logic                          b_adv;
  logic [nwsm_pkg::ScoreW-1:0]   diag_q, left_q, hash_q;
  logic [nwsm_pkg::ScoreW-1:0]   up, gap, subst;
  logic [nwsm_pkg::ScoreW-1:0]   diag_sum, up_sum, left_sum, best_du, score;
  logic [nwsm_pkg::ScoreW-1:0]   hash_in, hash_new;
  logic                          out_valid_q;
  logic [nwsm_pkg::ScoreW-1:0]   score_q, hash_out_q;
  logic [nwsm_pkg::PosW-1:0]     row_q, col_q;
  logic                          last_q;

  assign b_adv = b_valid_q && (!out_valid_q || out_ready_i);
  assign ready_o = !b_valid_q || b_adv;

  assign up = b_req_q.fwd ? left_q : up_rdata_i;
  assign gap = {{(nwsm_pkg::ScoreW-8){gap_cost_i[7]}}, gap_cost_i};
  assign subst = {{(nwsm_pkg::ScoreW-nwsm_pkg::SubstW){subst_rdata_i[nwsm_pkg::SubstW-1]}},
                  subst_rdata_i};
  assign diag_sum = diag_q + subst;
  assign up_sum = up + gap;
  assign left_sum = left_q + gap;
  assign best_du = ($signed(diag_sum) >= $signed(up_sum)) ? diag_sum : up_sum;

  always_comb begin
    if (b_req_q.first_row && b_req_q.first_col) begin
      score = '0;
    end else if (b_req_q.first_row) begin
      score = left_sum;
    end else if (b_req_q.first_col) begin
      score = up_sum;
    end else begin
      score = ($signed(best_du) >= $signed(left_sum)) ? best_du : left_sum;
    end
  end

  assign hash_in = (b_req_q.first_row && b_req_q.first_col) ? nwsm_pkg::HashSeed : hash_q;
  assign hash_new = ((hash_in << nwsm_pkg::HashShift) + hash_in) ^ score;

  assign row_wr_o.we = b_adv;
  assign row_wr_o.addr = b_req_q.col;
  assign row_wr_o.data = score;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      diag_q <= '0;
      left_q <= '0;
      hash_q <= nwsm_pkg::HashSeed;
    end else begin
      if (ready_o) begin
        b_valid_q <= req_valid_i;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
        diag_q <= up;
        left_q <= score;
        hash_q <= hash_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && req_valid_i) begin
      b_req_q <= req_i;
    end
    if (b_adv) begin
      score_q <= score;
      hash_out_q <= hash_new;
      row_q <= b_req_q.row;
      col_q <= b_req_q.col;
      last_q <= b_req_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o = score_q;
  assign hash_value_o = hash_out_q;
  assign row_index_o = row_q;
  assign col_index_o = col_q;
  assign last_cell_o = last_q;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nw_score_matrix_hash_core: a scoreboard class predicts
// every cell score, running hash and position. Plain tasks drive requests with
// random idle bursts and the config channel. Depends on nwsm_pkg and the core RTL.
module tb;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [nwsm_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned ItemTarget = 1300;
  localparam int unsigned IdleFreeTail = 200;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned QuietLimit = 2000;

  typedef struct packed {
    logic signed [31:0] score;
    logic [31:0]        hash;
    logic [9:0]         row;
    logic [9:0]         col;
    logic               last;
  } cell_result_t;

  class score_matrix_scoreboard;
    logic [7:0]   gap_cost;
    logic [10:0]  row_count;
    logic [10:0]  col_count;
    logic [31:0]  row_store [nwsm_pkg::MaxCols];
    bit           row_written [nwsm_pkg::MaxCols];
    logic [7:0]   subst_table [nwsm_pkg::SubstDepth];
    bit           subst_loaded [nwsm_pkg::SubstDepth];
    logic [31:0]  diag_value;
    logic [31:0]  left_value;
    logic [31:0]  running_hash;
    int unsigned  cur_row;
    int unsigned  cur_col;
    cell_result_t expected_cells [$];
    int unsigned  errors;

    function new();
      gap_cost = 8'hff;
      row_count = 11'd1;
      col_count = 11'd1;
      foreach (row_store[k]) begin
        row_store[k] = '0;
        row_written[k] = 1'b0;
      end
      foreach (subst_table[k]) begin
        subst_table[k] = '0;
        subst_loaded[k] = 1'b0;
      end
      errors = 0;
      restart_matrix();
    endfunction

    function void restart_matrix();
      cur_row = 0;
      cur_col = 0;
      diag_value = '0;
      left_value = '0;
      running_hash = nwsm_pkg::HashSeed;
    endfunction

    function int unsigned active_rows();
      int unsigned r;
      r = row_count;
      if (r < 1) r = 1;
      if (r > nwsm_pkg::DimLimit) r = nwsm_pkg::DimLimit;
      return r;
    endfunction

    function int unsigned active_cols();
      int unsigned c;
      c = col_count;
      if (c < 1) c = 1;
      if (c > nwsm_pkg::MaxCols) c = nwsm_pkg::MaxCols;
      if (c > nwsm_pkg::DimLimit) c = nwsm_pkg::DimLimit;
      return c;
    endfunction

    function bit outside_matrix();
      return cur_row >= active_rows() || cur_col >= active_cols();
    endfunction

    function void write_register(logic [nwsm_pkg::CfgIdxW-1:0] idx,
                                 logic [nwsm_pkg::DimW-1:0] data);
      if (idx == nwsm_pkg::CFG_GAP) gap_cost = data[7:0];
      else if (idx == nwsm_pkg::CFG_ROWS) row_count = data;
      else if (idx == nwsm_pkg::CFG_COLS) col_count = data;
    endfunction

    function void note_request(logic [1:0] op, logic [4:0] x, logic [4:0] y,
                               logic [7:0] sv);
      int unsigned i, j;
      logic [31:0] g, up, sub, score, via_up, via_left;
      cell_result_t res;
      if (op == nwsm_pkg::OP_LOAD) begin
        subst_table[{y, x}] = sv;
        subst_loaded[{y, x}] = 1'b1;
        return;
      end
      if (op == nwsm_pkg::OP_RESTART) begin
        restart_matrix();
        return;
      end
      if (op != nwsm_pkg::OP_CELL) return;
      if (outside_matrix()) restart_matrix();
      i = cur_row;
      j = cur_col;
      g = {{24{gap_cost[7]}}, gap_cost};
      up = row_store[j];
      if (i == 0 && j == 0) begin
        score = '0;
      end else if (i == 0) begin
        score = left_value + g;
      end else if (j == 0) begin
        score = up + g;
      end else begin
        sub = {{24{subst_table[{y, x}][7]}}, subst_table[{y, x}]};
        score = diag_value + sub;
        via_up = up + g;
        via_left = left_value + g;
        if ($signed(via_up) > $signed(score)) score = via_up;
        if ($signed(via_left) > $signed(score)) score = via_left;
      end
      diag_value = up;
      row_store[j] = score;
      row_written[j] = 1'b1;
      left_value = score;
      running_hash = ((running_hash << nwsm_pkg::HashShift) + running_hash) ^ score;
      res.score = score;
      res.hash = running_hash;
      res.row = 10'(i);
      res.col = 10'(j);
      res.last = (i == active_rows() - 1) && (j == active_cols() - 1);
      expected_cells.insert(expected_cells.size(), res);
      if (res.last) begin
        restart_matrix();
      end else begin
        cur_col = j + 1;
        if (cur_col >= active_cols()) begin
          cur_col = 0;
          cur_row = i + 1;
        end
      end
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result: score %0d hash %08h row %0d col %0d last %0b",
                   got.score, got.hash, got.row, got.col, got.last);
        return;
      end
      want = expected_cells.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("Cell mismatch, expected score %0d hash %08h row %0d col %0d last %0b",
                   want.score, want.hash, want.row, want.col, want.last);
          $display("                  actual score %0d hash %08h row %0d col %0d last %0b",
                   got.score, got.hash, got.row, got.col, got.last);
        end
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [nwsm_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [nwsm_pkg::DimW-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [1:0]                    opcode_i = '0;
  logic [nwsm_pkg::SymW-1:0]     x_symbol_i = '0;
  logic [nwsm_pkg::SymW-1:0]     y_symbol_i = '0;
  logic signed [7:0]             subst_value_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [31:0]            score_o;
  logic [31:0]                   hash_value_o;
  logic [9:0]                    row_index_o;
  logic [9:0]                    col_index_o;
  logic                          last_cell_o;

  score_matrix_scoreboard sb = new();
  cell_result_t observed_cell;
  bit           idle_on = 1'b1;
  int unsigned  stall_left = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  items_sent = 0;

  nw_score_matrix_hash_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .x_symbol_i    (x_symbol_i),
    .y_symbol_i    (y_symbol_i),
    .subst_value_i (subst_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .score_o       (score_o),
    .hash_value_o  (hash_value_o),
    .row_index_o   (row_index_o),
    .col_index_o   (col_index_o),
    .last_cell_o   (last_cell_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed_cell.score = score_o;
      observed_cell.hash = hash_value_o;
      observed_cell.row = row_index_o;
      observed_cell.col = col_index_o;
      observed_cell.last = last_cell_o;
      sb.check_result(observed_cell);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [4:0] x, logic [4:0] y, logic [7:0] sv);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    x_symbol_i <= x;
    y_symbol_i <= y;
    subst_value_i <= sv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, x, y, sv);
    if (op != OpUnused) items_sent++;
  endtask

  // A cell in row one or below needs its column of the stored row and, off the
  // header column, a loaded substitution entry; otherwise the matrix is restarted
  // or the entry is loaded first.
  task automatic send_cell(logic [4:0] x, logic [4:0] y, logic [7:0] sv);
    int unsigned r, c;
    r = sb.cur_row;
    c = sb.cur_col;
    if (sb.outside_matrix()) begin
      r = 0;
      c = 0;
    end
    if (r != 0 && !sb.row_written[c]) begin
      send(nwsm_pkg::OP_RESTART, x, y, sv);
    end else begin
      if (r != 0 && c != 0 && !sb.subst_loaded[{y, x}])
        send(nwsm_pkg::OP_LOAD, x, y, 8'($urandom));
      send(nwsm_pkg::OP_CELL, x, y, sv);
    end
  endtask

  task automatic write_reg(logic [nwsm_pkg::CfgIdxW-1:0] idx,
                           logic [nwsm_pkg::DimW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_register(idx, data);
  endtask

  task automatic configure(logic [7:0] gap, logic [nwsm_pkg::DimW-1:0] rows,
                           logic [nwsm_pkg::DimW-1:0] cols);
    write_reg(nwsm_pkg::CFG_GAP, {3'($urandom), gap});
    write_reg(nwsm_pkg::CFG_ROWS, rows);
    write_reg(nwsm_pkg::CFG_COLS, cols);
    if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, nwsm_pkg::DimW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_cells.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [nwsm_pkg::DimW-1:0] extreme_dim(int unsigned k);
    case (k)
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd1024;
      3: return 11'd1025;
      default: return 11'd2047;
    endcase
  endfunction

  initial begin
    int unsigned pick, phase_len;
    logic [4:0] x, y;
    logic [7:0] sv;
    logic [nwsm_pkg::DimW-1:0] rows, cols;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(nwsm_pkg::OP_CELL, 5'd31, 5'd0, 8'h7f);
    send(OpUnused, 5'd31, 5'd31, 8'hff);
    send(nwsm_pkg::OP_CELL, 5'd0, 5'd31, 8'h80);
    drain();
    configure(8'h80, 11'd3, 11'd3);
    send(nwsm_pkg::OP_LOAD, 5'd0, 5'd0, 8'h7f);
    send(nwsm_pkg::OP_LOAD, 5'd31, 5'd31, 8'h80);
    send(nwsm_pkg::OP_LOAD, 5'd31, 5'd0, 8'h00);
    send(nwsm_pkg::OP_LOAD, 5'd0, 5'd31, 8'hff);
    for (int k = 0; k < 5; k++) send_cell(k[0] ? 5'd31 : 5'd0, k[1] ? 5'd31 : 5'd0, 8'h55);
    send(nwsm_pkg::OP_RESTART, 5'd10, 5'd21, 8'haa);
    for (int k = 0; k < 9; k++) send_cell(k[0] ? 5'd31 : 5'd0, k[2] ? 5'd31 : 5'd0, 8'h00);
    drain();
    configure(8'h7f, 11'd0, 11'd2047);
    send_cell(5'd1, 5'd2, 8'h01);
    send_cell(5'd3, 5'd4, 8'hfe);
    drain();
    configure(8'h00, 11'd2, 11'd1);
    send_cell(5'd7, 5'd8, 8'h33);
    send_cell(5'd16, 5'd15, 8'hcc);

    while (items_sent < ItemTarget) begin
      drain();
      idle_on = (items_sent + IdleFreeTail < ItemTarget) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        rows = extreme_dim($urandom_range(0, 4));
        cols = extreme_dim($urandom_range(0, 4));
        phase_len = 30;
      end else begin
        rows = nwsm_pkg::DimW'($urandom_range(1, 6));
        cols = nwsm_pkg::DimW'($urandom_range(1, 8));
        phase_len = $urandom_range(20, 60);
      end
      configure(8'($urandom), rows, cols);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
          x = 5'($urandom);
          y = 5'($urandom);
        end else begin
          x = 5'($urandom_range(0, 3));
          y = 5'($urandom_range(0, 3));
        end
        sv = 8'($urandom);
        if (pick < 82) send_cell(x, y, sv);
        else if (pick < 92) send(nwsm_pkg::OP_LOAD, x, y, sv);
        else if (pick < 97) send(nwsm_pkg::OP_RESTART, x, y, sv);
        else send(OpUnused, x, y, sv);
      end
    end

    drain();
    if (sb.errors == 0 && sb.expected_cells.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- nw_score_matrix_hash_core.f -----
hw/rtl/nwsm_pkg.sv
hw/rtl/nwsm_ram.sv
hw/rtl/nwsm_sched.sv
hw/rtl/nwsm_cell.sv
hw/rtl/nw_score_matrix_hash_core.sv
dv/tb.sv
